[design/ptc_pkg.sv]
// Shared types and constants for the pressure/temperature compensation pipeline.
package ptc_pkg;

  // Calibration register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_PRESS_SENS = 3'd0,
    REG_PRESS_OFF  = 3'd1,
    REG_SENS_TC    = 3'd2,
    REG_OFF_TC     = 3'd3,
    REG_REF_TEMP   = 3'd4,
    REG_TEMP_COEFF = 3'd5
  } reg_idx_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RAW_W      = 24;
  localparam int TEMP_OUT_W = 19;
  localparam int PRESS_W    = 32;

  // 20.00 C and -15.00 C branch points, in centidegrees
  localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [19:0] TEMP_VLOW = -20'sd1500;

  typedef struct packed {
    logic [15:0] press_sens;
    logic [15:0] press_off;
    logic [15:0] sens_tc;
    logic [15:0] off_tc;
    logic [15:0] ref_temp;
    logic [15:0] temp_coeff;
  } cal_t;

  // First-order results leaving the front end
  typedef struct packed {
    logic                valid;
    logic [23:0]         d1;
    logic signed [19:0]  temp1;
    logic signed [39:0]  off1;
    logic signed [39:0]  sens1;
    logic [16:0]         t2lo;
    logic [12:0]         t2hi;
  } front_t;

  // Fully corrected terms leaving the second-order section
  typedef struct packed {
    logic                valid;
    logic [23:0]         d1;
    logic signed [19:0]  temp_f;
    logic signed [39:0]  off;
    logic signed [39:0]  sens;
  } second_t;

endpackage

[design/ptc_front.sv]
// Front end: dT, first-order multiplies, TEMP/OFF/SENS and T2 candidates (3 stages).
module ptc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [23:0]          in_raw_temp,
  input  logic [23:0]          in_raw_press,
  input  ptc_pkg::cal_t        cal,
  output ptc_pkg::front_t      fr
);
  import ptc_pkg::*;

  // stage 1: dT
  logic               v1_r;
  logic signed [24:0] dt1_r, dt1_nxt;
  logic [23:0]        d1_1_r;

  // stage 2: products
  logic               v2_r;
  logic signed [41:0] ptc_r, ptc_nxt;
  logic signed [41:0] poff_r, poff_nxt;
  logic signed [41:0] psens_r, psens_nxt;
  logic signed [49:0] dsq_full;
  logic [47:0]        dsq_r;
  logic [23:0]        d1_2_r;

  // stage 3
  front_t             fr_r, fr_nxt;
  logic signed [41:0] tsh, osh, ssh;
  logic [49:0]        dsq3;
  logic [50:0]        dsq5;

  assign dt1_nxt = $signed({1'b0, in_raw_temp}) - $signed({1'b0, cal.ref_temp, 8'b0});

  always_comb begin
    ptc_nxt   = dt1_r * $signed({1'b0, cal.temp_coeff});
    poff_nxt  = dt1_r * $signed({1'b0, cal.off_tc});
    psens_nxt = dt1_r * $signed({1'b0, cal.sens_tc});
    dsq_full  = dt1_r * dt1_r;
  end

  always_comb begin
    tsh  = ptc_r >>> 23;
    osh  = poff_r >>> 6;
    ssh  = psens_r >>> 7;
    dsq3 = {2'b0, dsq_r} + {1'b0, dsq_r, 1'b0};
    dsq5 = {3'b0, dsq_r} + {1'b0, dsq_r, 2'b0};
    fr_nxt.valid = v2_r;
    fr_nxt.d1    = d1_2_r;
    fr_nxt.temp1 = tsh[19:0] + TEMP_REF;
    fr_nxt.off1  = osh[39:0] + {7'b0, cal.press_off, 17'b0};
    fr_nxt.sens1 = ssh[39:0] + {8'b0, cal.press_sens, 16'b0};
    fr_nxt.t2lo  = dsq3[49:33];
    fr_nxt.t2hi  = dsq5[50:38];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      fr_r.valid <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      fr_r.valid <= fr_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    dt1_r   <= dt1_nxt;
    d1_1_r  <= in_raw_press;
    ptc_r   <= ptc_nxt;
    poff_r  <= poff_nxt;
    psens_r <= psens_nxt;
    dsq_r   <= dsq_full[47:0];
    d1_2_r  <= d1_1_r;
    fr_r.d1    <= fr_nxt.d1;
    fr_r.temp1 <= fr_nxt.temp1;
    fr_r.off1  <= fr_nxt.off1;
    fr_r.sens1 <= fr_nxt.sens1;
    fr_r.t2lo  <= fr_nxt.t2lo;
    fr_r.t2hi  <= fr_nxt.t2hi;
  end

  assign fr = fr_r;

endmodule

[design/ptc_second.sv]
// Second-order correction: branch select, squares, OFF2/SENS2 and final terms (3 stages).
module ptc_second (
  input  logic              clk,
  input  logic              rst_n,
  input  ptc_pkg::front_t   fr,
  output ptc_pkg::second_t  sc
);
  import ptc_pkg::*;

  // stage 4
  logic               v4_r, lo4_r, vlo4_r;
  logic               lo_nxt, vlo_nxt;
  logic signed [19:0] temp1, a_val, b_val, temp_f_nxt;
  logic signed [39:0] asq_full, bsq_full;
  logic [35:0]        asq_r, bsq_r;
  logic signed [19:0] temp4_r;
  logic signed [39:0] off4_r, sens4_r;
  logic [23:0]        d1_4_r;

  // stage 5
  logic               v5_r;
  logic [41:0]        a61, a29, b17, b9;
  logic [41:0]        off2_r, off2_nxt, sens2_r, sens2_nxt;
  logic signed [19:0] temp5_r;
  logic signed [39:0] off5_r, sens5_r;
  logic [23:0]        d1_5_r;

  // stage 6
  second_t            sc_r, sc_nxt;

  always_comb begin
    temp1    = $signed(fr.temp1);
    a_val    = temp1 - TEMP_REF;
    b_val    = temp1 - TEMP_VLOW;
    asq_full = a_val * a_val;
    bsq_full = b_val * b_val;
    lo_nxt   = temp1 < TEMP_REF;
    vlo_nxt  = temp1 < TEMP_VLOW;
    // T2 is taken off after the branch is chosen on the first-order TEMP
    temp_f_nxt = lo_nxt ? temp1 - $signed({3'b0, fr.t2lo})
                        : temp1 - $signed({7'b0, fr.t2hi});
  end

  always_comb begin
    a61 = 42'(asq_r) * 42'd61;
    a29 = 42'(asq_r) * 42'd29;
    b17 = 42'(bsq_r) * 42'd17;
    b9  = 42'(bsq_r) * 42'd9;
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (lo4_r) begin
      off2_nxt  = (a61 >> 4) + (vlo4_r ? b17 : 42'd0);
      sens2_nxt = (a29 >> 4) + (vlo4_r ? b9  : 42'd0);
    end
  end

  always_comb begin
    sc_nxt.valid  = v5_r;
    sc_nxt.d1     = d1_5_r;
    sc_nxt.temp_f = temp5_r;
    sc_nxt.off    = off5_r - $signed(off2_r[39:0]);
    sc_nxt.sens   = sens5_r - $signed(sens2_r[39:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      sc_r.valid <= 1'b0;
    end else begin
      v4_r <= fr.valid;
      v5_r <= v4_r;
      sc_r.valid <= sc_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    lo4_r   <= lo_nxt;
    vlo4_r  <= vlo_nxt;
    asq_r   <= asq_full[35:0];
    bsq_r   <= bsq_full[35:0];
    temp4_r <= temp_f_nxt;
    off4_r  <= $signed(fr.off1);
    sens4_r <= $signed(fr.sens1);
    d1_4_r  <= fr.d1;
    off2_r  <= off2_nxt;
    sens2_r <= sens2_nxt;
    temp5_r <= temp4_r;
    off5_r  <= off4_r;
    sens5_r <= sens4_r;
    d1_5_r  <= d1_4_r;
    sc_r.d1     <= sc_nxt.d1;
    sc_r.temp_f <= sc_nxt.temp_f;
    sc_r.off    <= sc_nxt.off;
    sc_r.sens   <= sc_nxt.sens;
  end

  assign sc = sc_r;

  // very-low branch only ever rides on top of the low branch
  a_vlo_in_lo: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && vlo4_r |-> lo4_r)
    else $error("very-low flag set outside low-temperature branch");

endmodule

[design/ptc_press.sv]
// Pressure: split 24x40 multiply, offset subtract, shift, clamp and output registers (4 stages).
module ptc_press (
  input  logic                clk,
  input  logic                rst_n,
  input  ptc_pkg::second_t    sc,
  output logic                out_valid,
  output logic signed [18:0]  out_temp_centi,
  output logic signed [31:0]  out_press_centi
);
  import ptc_pkg::*;

  localparam logic signed [44:0] P_MAX = 45'sd2147483647;
  localparam logic signed [44:0] P_MIN = -45'sd2147483648;

  // stage 7: partial products
  logic               v7_r;
  logic [43:0]        pp_lo_r;
  logic signed [44:0] pp_hi_r, pp_hi_nxt;
  logic signed [39:0] off7_r;
  logic signed [19:0] temp7_r;

  // stage 8: full product
  logic               v8_r;
  logic signed [63:0] hi_ext, prod_r, prod_nxt;
  logic signed [39:0] off8_r;
  logic signed [19:0] temp8_r;

  // stage 9: minus OFF
  logic               v9_r;
  logic signed [63:0] prod_sh;
  logic signed [44:0] q_r, q_nxt;
  logic signed [19:0] temp9_r;

  // stage 10: output
  logic               out_valid_r;
  logic signed [44:0] p_sh;
  logic signed [31:0] press_r, press_nxt;
  logic signed [18:0] temp_r;

  assign pp_hi_nxt = $signed({1'b0, sc.d1}) * $signed(sc.sens[39:20]);

  always_comb begin
    hi_ext   = 64'(pp_hi_r);
    prod_nxt = (hi_ext <<< 20) + $signed({20'b0, pp_lo_r});
    prod_sh  = prod_r >>> 21;
    q_nxt    = prod_sh[44:0] - 45'(off8_r);
    p_sh     = q_r >>> 15;
    if (p_sh > P_MAX) begin
      press_nxt = P_MAX[31:0];
    end else if (p_sh < P_MIN) begin
      press_nxt = P_MIN[31:0];
    end else begin
      press_nxt = p_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v7_r        <= sc.valid;
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      out_valid_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    pp_lo_r <= sc.d1 * sc.sens[19:0];
    pp_hi_r <= pp_hi_nxt;
    off7_r  <= $signed(sc.off);
    temp7_r <= $signed(sc.temp_f);
    prod_r  <= prod_nxt;
    off8_r  <= off7_r;
    temp8_r <= temp7_r;
    q_r     <= q_nxt;
    temp9_r <= temp8_r;
    press_r <= press_nxt;
    temp_r  <= temp9_r[18:0];
  end

  assign out_valid       = out_valid_r;
  assign out_temp_centi  = temp_r;
  assign out_press_centi = press_r;

endmodule

[design/pressure_temperature_compensation.sv]
// A transaction accepted on start emerges with out_valid after the ten register stages.
// Throughput: one sample pair per clock; busy is never raised.
// The ten register stages are set by the chain of dependent multiplies (dT, dT^2,
// (TEMP-2000)^2, then the 24x40 raw-pressure product split into two partial products).
// Reset (rst_n low, synchronous) clears the calibration registers to zero and empties
// the pipeline; the receiver cannot stall, so every result appears for one cycle.
module pressure_temperature_compensation (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [23:0]                        in_raw_temp,
  input  logic [23:0]                        in_raw_press,
  // result strobe
  output logic                               out_valid,
  output logic signed [18:0]                 out_temp_centi,
  output logic signed [31:0]                 out_press_centi,
  // calibration write port
  input  logic                               cfg_we,
  input  logic [ptc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ptc_pkg::*;

  cal_t    cal_r, cal_nxt;
  front_t  fr;
  second_t sc;
  logic    in_accept;

  // Fully pipelined: every stage advances every cycle, so the block never refuses a command.
  assign busy      = 1'b0;
  assign in_accept = start & ~busy;

  // Calibration decoder; indexes beyond the list are dropped.
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_PRESS_SENS: cal_nxt.press_sens = cfg_wdata;
        REG_PRESS_OFF:  cal_nxt.press_off  = cfg_wdata;
        REG_SENS_TC:    cal_nxt.sens_tc    = cfg_wdata;
        REG_OFF_TC:     cal_nxt.off_tc     = cfg_wdata;
        REG_REF_TEMP:   cal_nxt.ref_temp   = cfg_wdata;
        REG_TEMP_COEFF: cal_nxt.temp_coeff = cfg_wdata;
        default:        cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  // Stages 1-3: dT, first-order products, TEMP/OFF/SENS, T2 candidates
  ptc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_accept),
    .in_raw_temp  (in_raw_temp),
    .in_raw_press (in_raw_press),
    .cal          (cal_r),
    .fr           (fr)
  );

  // Stages 4-6: low / very-low / high branch and OFF2, SENS2
  ptc_second u_second (
    .clk   (clk),
    .rst_n (rst_n),
    .fr    (fr),
    .sc    (sc)
  );

  // Stages 7-10: pressure product, shifts, 32-bit clamp, output registers
  ptc_press u_press (
    .clk             (clk),
    .rst_n           (rst_n),
    .sc              (sc),
    .out_valid       (out_valid),
    .out_temp_centi  (out_temp_centi),
    .out_press_centi (out_press_centi)
  );

  // Every accepted transaction yields a result.
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##10 out_valid)
    else $error("accepted transaction produced no result");

  // No result without a matching earlier transaction.
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, 10))
    else $error("result without matching transaction");

endmodule
